>>> hdl/profile_edge_subpixel_finder_top_assert.svh
// Assertion macros for the profile edge finder.
// Used by the top level only; needs nothing else.
`ifndef PROFILE_EDGE_SUBPIXEL_FINDER_TOP_ASSERT_SVH
`define PROFILE_EDGE_SUBPIXEL_FINDER_TOP_ASSERT_SVH

// same-cycle implication
`define PSF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/psf_pkg.sv
// Shared types and constants for the profile edge finder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psf_pkg;

   localparam int unsigned MAX_HALF_LENGTH_DEF = 127;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned STRENGTH_W = 15;
   localparam int unsigned DIV_W = 27;

   localparam logic [1:0] POL_ANY     = 2'd0;
   localparam logic [1:0] POL_RISING  = 2'd1;
   localparam logic [1:0] POL_FALLING = 2'd2;

   localparam logic [1:0] CSR_HALF_LENGTH = 2'd0;
   localparam logic [1:0] CSR_SMOOTHING   = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD   = 2'd2;
   localparam logic [1:0] CSR_POLARITY    = 2'd3;

   typedef struct packed {
      logic [1:0]            passes;
      logic [1:0]            polarity;
      logic [STRENGTH_W-1:0] threshold;
   } sweep_cfg_type;

endpackage
`default_nettype wire

>>> hdl/psf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module psf_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 255
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> hdl/psf_sweep.sv
// Sweep engine: in-place smoothing passes and gradient pass over the profile RAM,
// tracking the strongest gradient. Depends on psf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psf_sweep #(
   parameter int unsigned AW = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [AW-1:0]          len,
   input  wire psf_pkg::sweep_cfg_type cfg,
   output logic                        rd_en,
   output logic [AW-1:0]               rd_addr,
   input  wire logic [15:0]            rd_data,
   output logic                        wr_en,
   output logic [AW-1:0]               wr_addr,
   output logic [15:0]                 wr_data,
   output logic                        done,
   output logic [AW-1:0]               best_pos,
   output logic [14:0]                 best_mag
);
   import psf_pkg::*;

   logic            run_ff, run_in;
   logic            issue_ff, issue_in;
   logic [AW-1:0]   rd_idx_ff, rd_idx_in;
   logic            vld_ff;
   logic [AW-1:0]   idx_ff;
   logic [15:0]     w1_ff, w2_ff;
   logic [1:0]      pass_ff, pass_in, passes_ff;
   logic [AW-1:0]   len_ff;
   logic [1:0]      pol_ff;
   logic [AW-1:0]   best_pos_ff, best_pos_in;
   logic [14:0]     best_mag_ff, best_mag_in;
   logic            done_ff, done_in;

   logic            grad_mode, proc, last;
   logic [17:0]     sum;
   logic [16:0]     diff, absd, mag17;
   logic [14:0]     mag;
   logic [15:0]     grad;
   logic            pol_ok;

   assign grad_mode = (pass_ff == passes_ff);
   assign proc      = vld_ff && (idx_ff >= AW'(2));
   assign last      = vld_ff && (idx_ff == len_ff - AW'(1));

   always_comb begin
      sum   = 18'(w2_ff) + {1'b0, w1_ff, 1'b0} + 18'(rd_data) + 18'd2;
      diff  = {1'b0, rd_data} - {1'b0, w2_ff};
      absd  = diff[16] ? (17'd0 - diff) : diff;
      mag17 = (absd + 17'd1) >> 1;
      mag   = mag17[15] ? 15'h7fff : mag17[14:0];
      grad  = diff[16] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
      unique case (pol_ff)
         POL_ANY:     pol_ok = 1'b1;
         POL_RISING:  pol_ok = !diff[16] && (diff != 17'd0);
         POL_FALLING: pol_ok = diff[16];
         default:     pol_ok = 1'b0;
      endcase
   end

   assign rd_en   = issue_ff;
   assign rd_addr = rd_idx_ff;
   assign wr_en   = proc;
   assign wr_addr = idx_ff - AW'(1);
   assign wr_data = grad_mode ? grad : sum[17:2];

   always_comb begin
      run_in      = run_ff;
      issue_in    = issue_ff;
      rd_idx_in   = rd_idx_ff;
      pass_in     = pass_ff;
      best_pos_in = best_pos_ff;
      best_mag_in = best_mag_ff;
      done_in     = 1'b0;
      if (start) begin
         run_in      = 1'b1;
         issue_in    = 1'b1;
         rd_idx_in   = '0;
         pass_in     = '0;
         best_pos_in = '0;
         best_mag_in = cfg.threshold;
      end else if (run_ff) begin
         if (issue_ff) begin
            rd_idx_in = rd_idx_ff + AW'(1);
            if (rd_idx_ff == len_ff - AW'(1)) begin
               issue_in = 1'b0;
            end
         end
         if (proc && grad_mode && pol_ok && (mag > best_mag_ff)) begin
            best_mag_in = mag;
            best_pos_in = idx_ff - AW'(1);
         end
         if (last) begin
            if (grad_mode) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               pass_in   = pass_ff + 2'd1;
               issue_in  = 1'b1;
               rd_idx_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         issue_ff <= 1'b0;
         vld_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         run_ff   <= run_in;
         issue_ff <= issue_in;
         vld_ff   <= issue_ff && !start;
         done_ff  <= done_in;
      end
      rd_idx_ff   <= rd_idx_in;
      idx_ff      <= rd_idx_ff;
      pass_ff     <= pass_in;
      best_pos_ff <= best_pos_in;
      best_mag_ff <= best_mag_in;
      if (vld_ff) begin
         w1_ff <= rd_data;
         w2_ff <= w1_ff;
      end
      if (start) begin
         len_ff    <= len;
         pol_ff    <= cfg.polarity;
         passes_ff <= (cfg.passes == 2'd3) ? 2'd2 : cfg.passes;
      end
   end

   assign done     = done_ff;
   assign best_pos = best_pos_ff;
   assign best_mag = best_mag_ff;
endmodule
`default_nettype wire

>>> hdl/psf_div.sv
// Parabola offset divider: round(128*num/den) clamped to +-128, one quotient
// bit per cycle. Depends on psf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psf_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [16:0] num,
   input  wire logic signed [18:0] den,
   output logic                    done,
   output logic signed [8:0]       quot
);
   import psf_pkg::*;

   logic             busy_ff, done_ff;
   logic [2:0]       cnt_ff;
   logic [DIV_W-1:0] rem_ff, dcur_ff;
   logic [8:0]       q_ff;
   logic             neg_ff;
   logic [16:0]      an;
   logic [18:0]      ad;
   logic [DIV_W-1:0] n_full, d_full;
   logic             sat;
   logic             ge;
   logic [8:0]       q_next, q_cl;

   always_comb begin
      an     = num[16] ? (17'd0 - num) : num;
      ad     = den[18] ? (19'd0 - den) : den;
      n_full = DIV_W'({an, 8'd0}) + DIV_W'(ad);
      d_full = DIV_W'({ad, 1'b0});
      sat    = n_full >= (d_full << 8);
      ge     = rem_ff >= dcur_ff;
      q_next = {q_ff[7:0], ge};
      q_cl   = (q_next > 9'd128) ? 9'd128 : q_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (start) begin
            done_ff <= sat;
            busy_ff <= !sat;
         end else if (busy_ff && cnt_ff == 3'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            done_ff <= 1'b0;
         end
      end
      if (start) begin
         neg_ff  <= num[16] != den[18];
         rem_ff  <= n_full;
         dcur_ff <= d_full << 7;
         cnt_ff  <= 3'd7;
         q_ff    <= sat ? 9'd128 : 9'd0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - dcur_ff;
         end
         dcur_ff <= dcur_ff >> 1;
         cnt_ff  <= cnt_ff - 3'd1;
         q_ff    <= q_cl;
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? (9'sd0 - $signed(q_ff)) : $signed(q_ff);
endmodule
`default_nettype wire

>>> hdl/profile_edge_subpixel_finder_top.sv
// Profile edge finder with subpixel parabolic refinement: top level.
// Depends on psf_pkg, psf_ram, psf_sweep, psf_div and the assertion header.
//
// Use: samples of one profile (2*half_length+1 of them) enter on req_, one
// item per cycle, and are written to the profile RAM. After the last sample
// the block stops taking items (req_ready low) and sweeps the RAM once per
// smoothing pass plus once for the gradient, each sweep reading the profile
// through the single RAM read port; then ST_FETCH0 to ST_FETCH3 fetch the peak
// neighbourhood, ST_PARA checks the curvature and ST_DIV divides for the
// offset. When no edge is found the fetch, curvature and divide steps are
// skipped, and a zero curvature skips the divide.
// A profile of one sample skips the sweep and reports no edge.
// One result item per profile leaves on rsp_; it sits in an output register
// until taken, and the next profile is collected meanwhile. A stalled rsp_
// only holds the block once a further result is ready.
// Reset clears control state and the configuration registers (half_length
// 16, one smoothing pass, threshold 2560, any polarity). No clearing pass.
// csr_ writes take effect at once; write only while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "profile_edge_subpixel_finder_top_assert.svh"
module profile_edge_subpixel_finder_top #(
   parameter int unsigned MAX_HALF_LENGTH = psf_pkg::MAX_HALF_LENGTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [15:0]        req_profile_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_edge_found,
   output logic signed [15:0]      rsp_edge_offset,
   output logic [14:0]             rsp_edge_strength,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [14:0]        csr_wr_data
);
   import psf_pkg::*;

   localparam int unsigned DEPTH = 2 * MAX_HALF_LENGTH + 1;
   localparam int unsigned AW    = $clog2(DEPTH);

   typedef enum logic [3:0] {
      ST_COLLECT, ST_SWEEP, ST_FETCH0, ST_FETCH1, ST_FETCH2, ST_FETCH3,
      ST_PARA, ST_DIV, ST_EMIT
   } state_type;

   state_type       state_ff;
   logic [6:0]      half_length_ff;
   logic [1:0]      smoothing_ff, polarity_ff;
   logic [14:0]     threshold_ff;
   logic [AW-1:0]   cnt_ff, len_ff, half_ff;
   logic [AW-1:0]   best_pos_ff;
   logic [14:0]     best_mag_ff;
   logic            found_ff, z0_ff, z2_ff;
   logic signed [15:0] y0_ff, y1_ff, y2_ff;
   logic signed [8:0]  off_ff;
   logic            sweep_start_ff, div_start_ff;
   logic            rsp_valid_ff;
   logic            rsp_found_ff;
   logic [15:0]     rsp_offset_ff;
   logic [14:0]     rsp_strength_ff;

   logic [AW-1:0]   h_sel, len_new, len_now;
   logic            accept;
   sweep_cfg_type   sweep_cfg;
   logic            sw_rd_en, sw_wr_en, sw_done;
   logic [AW-1:0]   sw_rd_addr, sw_wr_addr, sw_best_pos;
   logic [15:0]     sw_wr_data;
   logic [14:0]     sw_best_mag;
   logic            ram_wr_en, ram_rd_en;
   logic [AW-1:0]   ram_wr_addr, ram_rd_addr;
   logic [15:0]     ram_wr_data, ram_rd_data;
   logic signed [16:0] num;
   logic signed [18:0] den;
   logic            div_done;
   logic signed [8:0]  div_quot;
   logic signed [31:0] total;
   logic [15:0]     total_sat;
   logic            out_free;
   logic            emit;

   always_comb begin
      if (32'(half_length_ff) > MAX_HALF_LENGTH) begin
         h_sel = AW'(MAX_HALF_LENGTH);
      end else begin
         h_sel = AW'(half_length_ff);
      end
      len_new = AW'({h_sel, 1'b1});
      len_now = (cnt_ff == '0) ? len_new : len_ff;
   end

   assign req_ready = (state_ff == ST_COLLECT);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = (state_ff == ST_EMIT) && out_free;

   assign sweep_cfg.passes    = smoothing_ff;
   assign sweep_cfg.polarity  = polarity_ff;
   assign sweep_cfg.threshold = threshold_ff;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_ff;
      ram_wr_data = req_profile_sample;
      ram_rd_en   = 1'b0;
      ram_rd_addr = best_pos_ff - AW'(1);
      unique case (state_ff)
         ST_COLLECT: ram_wr_en = accept;
         ST_SWEEP: begin
            ram_wr_en   = sw_wr_en;
            ram_wr_addr = sw_wr_addr;
            ram_wr_data = sw_wr_data;
            ram_rd_en   = sw_rd_en;
            ram_rd_addr = sw_rd_addr;
         end
         ST_FETCH0: ram_rd_en = 1'b1;
         ST_FETCH1: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = best_pos_ff;
         end
         ST_FETCH2: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = best_pos_ff + AW'(1);
         end
         default: ram_rd_en = 1'b0;
      endcase
   end

   psf_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   psf_sweep #(.AW(AW)) u_sweep (
      .clock    (clock),
      .reset    (reset),
      .start    (sweep_start_ff),
      .len      (len_ff),
      .cfg      (sweep_cfg),
      .rd_en    (sw_rd_en),
      .rd_addr  (sw_rd_addr),
      .rd_data  (ram_rd_data),
      .wr_en    (sw_wr_en),
      .wr_addr  (sw_wr_addr),
      .wr_data  (sw_wr_data),
      .done     (sw_done),
      .best_pos (sw_best_pos),
      .best_mag (sw_best_mag)
   );

   assign num = 17'(y0_ff) - 17'(y2_ff);
   assign den = 19'(y0_ff) - (19'(y1_ff) <<< 1) + 19'(y2_ff);

   psf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      total = ($signed({1'b0, best_pos_ff}) - $signed({1'b0, half_ff})) * 256
              + 32'(off_ff);
      if (total > 32'sd32767) begin
         total_sat = 16'h7fff;
      end else if (total < -32'sd32768) begin
         total_sat = 16'h8000;
      end else begin
         total_sat = total[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_COLLECT;
         cnt_ff         <= '0;
         sweep_start_ff <= 1'b0;
         div_start_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         half_length_ff <= 7'd16;
         smoothing_ff   <= 2'd1;
         threshold_ff   <= 15'd2560;
         polarity_ff    <= POL_ANY;
      end else begin
         sweep_start_ff <= 1'b0;
         div_start_ff   <= 1'b0;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_HALF_LENGTH: half_length_ff <= csr_wr_data[6:0];
               CSR_SMOOTHING:   smoothing_ff   <= csr_wr_data[1:0];
               CSR_THRESHOLD:   threshold_ff   <= csr_wr_data;
               CSR_POLARITY:    polarity_ff    <= csr_wr_data[1:0];
            endcase
         end
         unique case (state_ff)
            ST_COLLECT: begin
               if (accept) begin
                  if (cnt_ff == '0) begin
                     len_ff  <= len_new;
                     half_ff <= h_sel;
                  end
                  if (cnt_ff + AW'(1) == len_now) begin
                     cnt_ff <= '0;
                     if (len_now < AW'(3)) begin
                        found_ff <= 1'b0;
                        state_ff <= ST_EMIT;
                     end else begin
                        sweep_start_ff <= 1'b1;
                        state_ff       <= ST_SWEEP;
                     end
                  end else begin
                     cnt_ff <= cnt_ff + AW'(1);
                  end
               end
            end
            ST_SWEEP: begin
               if (sw_done) begin
                  best_pos_ff <= sw_best_pos;
                  best_mag_ff <= sw_best_mag;
                  z0_ff       <= sw_best_pos == AW'(1);
                  z2_ff       <= sw_best_pos + AW'(2) == len_ff;
                  found_ff    <= sw_best_pos != '0;
                  off_ff      <= '0;
                  state_ff    <= (sw_best_pos == '0) ? ST_EMIT : ST_FETCH0;
               end
            end
            ST_FETCH0: state_ff <= ST_FETCH1;
            ST_FETCH1: begin
               y0_ff    <= z0_ff ? 16'sd0 : $signed(ram_rd_data);
               state_ff <= ST_FETCH2;
            end
            ST_FETCH2: begin
               y1_ff    <= $signed(ram_rd_data);
               state_ff <= ST_FETCH3;
            end
            ST_FETCH3: begin
               y2_ff    <= z2_ff ? 16'sd0 : $signed(ram_rd_data);
               state_ff <= ST_PARA;
            end
            ST_PARA: begin
               if (den == '0) begin
                  state_ff <= ST_EMIT;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  off_ff   <= div_quot;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_found_ff    <= found_ff;
                  rsp_offset_ff   <= found_ff ? total_sat : 16'd0;
                  rsp_strength_ff <= found_ff ? best_mag_ff : 15'd0;
                  state_ff        <= ST_COLLECT;
               end
            end
            default: state_ff <= ST_COLLECT;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_edge_found    = rsp_found_ff;
   assign rsp_edge_offset   = $signed(rsp_offset_ff);
   assign rsp_edge_strength = rsp_strength_ff;

   `PSF_ASSERT_NOW(a_found_strong, clock, reset, rsp_valid && rsp_edge_found, rsp_edge_strength > threshold_ff, "edge strength not above threshold")
   `PSF_ASSERT_NOW(a_none_zero, clock, reset, rsp_valid && !rsp_edge_found, rsp_edge_offset == 16'sd0 && rsp_edge_strength == 15'd0, "no-edge item carries data")
   `PSF_ASSERT_NOW(a_div_range, clock, reset, div_done, div_quot <= 9'sd128 && div_quot >= -9'sd128, "offset beyond half a pixel")
   `PSF_ASSERT_NEXT(a_sweep_quiet, clock, reset, state_ff == ST_COLLECT, !sw_wr_en, "sweep writes while collecting")
endmodule
`default_nettype wire

>>> tb/profile_edge_subpixel_finder_top_tb.sv
// Self-checking testbench for profile_edge_subpixel_finder_top.
// Drives profiles over req_, checks rsp_ against an in-bench edge predictor;
// depends on psf_pkg and the top level only.
`timescale 1ns / 1ps
module profile_edge_subpixel_finder_top_tb;
   import psf_pkg::*;

   localparam logic [1:0] POL_NONE = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_OFF_CYCLES = 1500;

   typedef enum bit {ROW_CFG, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [1:0]         idx;
      logic [15:0]        val;
      bit                 typed;
      bit                 e_found;
      logic signed [15:0] e_off;
      logic [14:0]        e_str;
   } stim_row_type;

   typedef struct {
      bit                 found;
      logic signed [15:0] offset;
      logic [14:0]        strength;
   } edge_result_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [15:0] req_profile_sample;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_edge_found;
   logic signed [15:0] rsp_edge_offset;
   logic [14:0] rsp_edge_strength;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [14:0] csr_wr_data;

   // shadow configuration
   logic [6:0]  cfg_half_length;
   logic [1:0]  cfg_passes;
   logic [14:0] cfg_threshold;
   logic [1:0]  cfg_polarity;

   logic [15:0] profile_q[$];
   int unsigned latched_len;
   edge_result_type pending_edges[$];
   stim_row_type dir_tab[$];

   int errors;
   int samples_sent;
   int edges_checked;
   int edges_found;
   int quiet_cycles;
   bit calm;
   bit hold_off_req;

   profile_edge_subpixel_finder_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic edge_result_type locate_edge(input logic [15:0] prof[$]);
      int m;
      int p;
      int j;
      int npass;
      int d;
      int mag;
      int best_pos;
      int best_mag;
      int off;
      int total;
      longint num;
      longint den;
      longint an;
      longint ad;
      longint q;
      bit ok;
      int vals[];
      int tmp[];
      int grad[];
      edge_result_type r;
      m = prof.size();
      vals = new[m];
      grad = new[m];
      foreach (prof[i]) vals[i] = prof[i];
      foreach (grad[i]) grad[i] = 0;
      npass = (cfg_passes > 2) ? 2 : cfg_passes;
      for (p = 0; p < npass; p++) begin
         tmp = vals;
         for (j = 1; j + 1 < m; j++)
            tmp[j] = (vals[j-1] + 2 * vals[j] + vals[j+1] + 2) >> 2;
         vals = tmp;
      end
      best_pos = 0;
      best_mag = cfg_threshold;
      for (j = 1; j + 1 < m; j++) begin
         d = vals[j+1] - vals[j-1];
         mag = ((d < 0 ? -d : d) + 1) >> 1;
         if (mag > 32767) mag = 32767;
         grad[j] = (d < 0) ? -mag : mag;
         ok = (cfg_polarity == POL_ANY) ||
              (cfg_polarity == POL_RISING && grad[j] > 0) ||
              (cfg_polarity == POL_FALLING && grad[j] < 0);
         if (ok && mag > best_mag) begin
            best_mag = mag;
            best_pos = j;
         end
      end
      r.found = 1'b0;
      r.offset = '0;
      r.strength = '0;
      if (best_pos == 0) return r;
      num = grad[best_pos-1] - grad[best_pos+1];
      den = grad[best_pos-1] - 2 * grad[best_pos] + grad[best_pos+1];
      off = 0;
      if (den != 0) begin
         an = (num < 0 ? -num : num) * 128;
         ad = den < 0 ? -den : den;
         q = (2 * an + ad) / (2 * ad);
         if (q > 128) q = 128;
         off = ((num < 0) != (den < 0)) ? -int'(q) : int'(q);
      end
      total = (best_pos - (m - 1) / 2) * 256 + off;
      if (total > 32767) total = 32767;
      if (total < -32768) total = -32768;
      r.found = 1'b1;
      r.offset = total[15:0];
      r.strength = best_mag[14:0];
      return r;
   endfunction

   // returns 1 when the item closed a profile
   function automatic bit take_sample(input logic [15:0] s);
      if (profile_q.size() == 0) latched_len = 2 * cfg_half_length + 1;
      profile_q.insert(profile_q.size(), s);
      samples_sent++;
      if (profile_q.size() < latched_len) return 1'b0;
      pending_edges.insert(pending_edges.size(), locate_edge(profile_q));
      profile_q.delete();
      return 1'b1;
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
      req_valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_HALF_LENGTH: cfg_half_length = val[6:0];
         CSR_SMOOTHING:   cfg_passes = val[1:0];
         CSR_THRESHOLD:   cfg_threshold = val;
         default:         cfg_polarity = val[1:0];
      endcase
   endtask

   task automatic send_sample(input logic [15:0] s, output bit closed);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_profile_sample <= s;
      do @(posedge clock); while (!req_ready);
      closed = take_sample(s);
   endtask

   function automatic stim_row_type cfg_row(input logic [1:0] idx, input logic [15:0] val);
      stim_row_type r;
      r = '{ROW_CFG, idx, val, 1'b0, 1'b0, 16'sd0, 15'd0};
      return r;
   endfunction

   function automatic stim_row_type smp_row(input logic [15:0] val);
      stim_row_type r;
      r = '{ROW_SAMPLE, 2'd0, val, 1'b0, 1'b0, 16'sd0, 15'd0};
      return r;
   endfunction

   function automatic stim_row_type last_row(input logic [15:0] val, input bit f,
                                             input logic [14:0] str);
      stim_row_type r;
      r = '{ROW_SAMPLE, 2'd0, val, 1'b1, f, 16'sd0, str};
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      edge_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_edges.size() == 0) begin
            $error("unexpected result item");
            errors++;
         end else begin
            e = pending_edges.pop_front();
            edges_checked++;
            if (e.found) edges_found++;
            if (rsp_edge_found !== e.found) begin
               $error("edge_found exp %0d got %0d", e.found, rsp_edge_found);
               errors++;
            end
            if (rsp_edge_offset !== e.offset) begin
               $error("edge_offset exp %0d got %0d", e.offset, rsp_edge_offset);
               errors++;
            end
            if (rsp_edge_strength !== e.strength) begin
               $error("edge_strength exp %0d got %0d", e.strength, rsp_edge_strength);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result receiver
   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      int n;
      int phase;
      int m;
      int style;
      int lo;
      int hi;
      int step_at;
      int noise;
      int v;
      bit closed;
      stim_row_type row;
      errors = 0;
      samples_sent = 0;
      edges_checked = 0;
      edges_found = 0;
      quiet_cycles = 0;
      calm = 1'b0;
      hold_off_req = 1'b0;
      req_valid <= 1'b0;
      req_profile_sample <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_HALF_LENGTH;
      csr_wr_data <= '0;
      cfg_half_length = 7'd16;
      cfg_passes = 2'd1;
      cfg_threshold = 15'd2560;
      cfg_polarity = POL_ANY;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_tab = '{
         cfg_row(CSR_HALF_LENGTH, 16'd0), cfg_row(CSR_SMOOTHING, 16'd0),
         cfg_row(CSR_THRESHOLD, 16'd0), cfg_row(CSR_POLARITY, POL_ANY),
         last_row(16'hFFFF, 1'b0, 15'd0), last_row(16'h0000, 1'b0, 15'd0),
         cfg_row(CSR_HALF_LENGTH, 16'd1),
         smp_row(16'h0000), smp_row(16'h0000), last_row(16'hFFFF, 1'b1, 15'd32767),
         smp_row(16'hFFFF), smp_row(16'hFFFF), last_row(16'h0000, 1'b1, 15'd32767),
         smp_row(16'h1234), smp_row(16'h1234), last_row(16'h1234, 1'b0, 15'd0),
         cfg_row(CSR_POLARITY, POL_RISING),
         smp_row(16'hFFFF), smp_row(16'hFFFF), last_row(16'h0000, 1'b0, 15'd0),
         cfg_row(CSR_POLARITY, POL_FALLING),
         smp_row(16'h0000), smp_row(16'h0000), last_row(16'hFFFF, 1'b0, 15'd0),
         cfg_row(CSR_POLARITY, POL_NONE),
         smp_row(16'hFFFF), smp_row(16'h0000), last_row(16'h0000, 1'b0, 15'd0),
         cfg_row(CSR_POLARITY, POL_ANY), cfg_row(CSR_SMOOTHING, 16'd3),
         cfg_row(CSR_THRESHOLD, 16'd32640), cfg_row(CSR_HALF_LENGTH, 16'd3),
         smp_row(16'h0000), smp_row(16'h0000), smp_row(16'h0000),
         smp_row(16'hFFFF), smp_row(16'hFFFF), smp_row(16'hFFFF), smp_row(16'hFFFF)
      };
      foreach (dir_tab[i]) begin
         row = dir_tab[i];
         if (row.kind == ROW_CFG) begin
            write_reg(row.idx, row.val[14:0]);
         end else begin
            send_sample(row.val, closed);
            if (closed && row.typed) begin
               pending_edges[pending_edges.size() - 1] = '{row.e_found, row.e_off, row.e_str};
            end
         end
      end

      // random phases, each a fresh setting and a few profiles
      phase = 0;
      while (samples_sent < 450) begin
         if (samples_sent > 380) calm = 1'b1;
         write_reg(CSR_HALF_LENGTH, (phase == 3) ? 15'd127 :
                   15'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 20)
                                                   : $urandom_range(1, 6)));
         write_reg(CSR_SMOOTHING, 15'($urandom_range(0, 3)));
         write_reg(CSR_THRESHOLD, 15'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                                  : $urandom_range(0, 3000)));
         write_reg(CSR_POLARITY, ($urandom_range(0, 7) == 0) ? 15'(POL_NONE)
                                                             : 15'($urandom_range(0, 2)));
         if (phase == 1) hold_off_req = 1'b1;
         m = 2 * cfg_half_length + 1;
         repeat ((phase == 3) ? 1 : (phase == 1) ? 3 : $urandom_range(1, 4)) begin
            style = $urandom_range(0, 9);
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(0, 65535);
            step_at = $urandom_range(0, m - 1);
            noise = $urandom_range(0, 600);
            for (n = 0; n < m; n++) begin
               if (style < 7) begin
                  v = ((n < step_at) ? lo : hi) + $urandom_range(0, 2 * noise) - noise;
                  if (v < 0) v = 0;
                  if (v > 65535) v = 65535;
               end else if (style < 9) begin
                  v = $urandom_range(0, 65535);
               end else begin
                  v = lo;
               end
               send_sample(v[15:0], closed);
            end
         end
         phase++;
      end
      req_valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Run covered %0d samples over %0d setting phases; %0d results, %0d with an edge.",
               samples_sent, phase, edges_checked, edges_found);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
